// ===== rtl/point_in_polygon_test_top_defines.svh =====
// Assertion macros shared by the point-in-polygon RTL.
`ifndef POINT_IN_POLYGON_TEST_TOP_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_TOP_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define PIP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent this cycle implies consequent in the next cycle.
`define PIP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pip_pkg.sv =====
// Shared constants, types and states of the point-in-polygon block.
package pip_pkg;

  localparam int COORD_BITS     = 32;
  localparam int FRACTION_BITS  = 16;
  localparam int COUNT_BITS     = 16;
  localparam int IN_BITS        = 32;
  localparam int TOL_BITS       = 16;
  localparam int OUT_COUNT_BITS = 16;
  localparam int DIFF_BITS      = COORD_BITS + 1;
  localparam int PROD_BITS      = 2 * COORD_BITS;
  localparam int SPROD_BITS     = PROD_BITS + 1;
  localparam int QUEUE_DEPTH    = 4;
  localparam int NUM_PRODS      = 4;

  // 0.001 rounded to the nearest fixed-point step
  localparam logic [TOL_BITS-1:0] TOL_RESET =
    TOL_BITS'(((64'd1 << FRACTION_BITS) + 64'd500) / 64'd1000);

  // largest coordinate, end of the ray
  localparam logic signed [DIFF_BITS-1:0] FAR_COORD =
    DIFF_BITS'((64'd1 << (COORD_BITS - 1)) - 64'd1);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic   clr;   // first vertex: clear count and parity
    logic   test;  // run the edge test
    logic   emit;  // give the result after this edge
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
    coord_t qx;
    coord_t qy;
  } edge_job_t;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_LOAD   = 6'b000010,
    ST_MUL    = 6'b000100,
    ST_SIGN   = 6'b001000,
    ST_EVAL   = 6'b010000,
    ST_COMMIT = 6'b100000
  } back_state_e;

endpackage

// ===== rtl/pip_queue.sv =====
// Short job queue between the vertex front end and the edge tester.
module pip_queue
  import pip_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  edge_job_t data_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output edge_job_t data_o
);

  localparam int PtrBits = $clog2(QUEUE_DEPTH);
  localparam int CntBits = $clog2(QUEUE_DEPTH + 1);

  edge_job_t          mem_q [QUEUE_DEPTH];
  logic [PtrBits-1:0] wr_q, rd_q;
  logic [CntBits-1:0] cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CntBits'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`include "point_in_polygon_test_top_defines.svh"

  `PIP_ASSERT(a_no_overflow, !(push_i && full_o), "job queue pushed while full")
  `PIP_ASSERT_NEXT(a_push_fills, push_i && !full_o, !empty_o, "queue empty after push")

endmodule

// ===== rtl/pip_front.sv =====
// Front end: take vertices, track the run and issue edge jobs.
module pip_front
  import pip_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  output logic                       full_o,
  input  logic signed [IN_BITS-1:0]  query_x_i,
  input  logic signed [IN_BITS-1:0]  query_y_i,
  input  logic signed [IN_BITS-1:0]  vertex_x_i,
  input  logic signed [IN_BITS-1:0]  vertex_y_i,
  input  logic                       first_vertex_i,
  input  logic                       last_vertex_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output edge_job_t                  q_data_o
);

  coord_t    start_x_q, start_y_q, prior_x_q, prior_y_q, hq_x_q, hq_y_q;
  coord_t    vx, vy;
  logic      pend_q;
  edge_job_t pend_job_q, job_now, job_close;
  logic      accept;

  assign vx = COORD_BITS'(vertex_x_i);
  assign vy = COORD_BITS'(vertex_y_i);

  // a pending closing edge blocks new vertices until it is queued
  assign full_o = pend_q || q_full_i;
  assign accept = push_i && !full_o;

  always_comb begin
    job_now      = '0;
    job_now.x1   = prior_x_q;
    job_now.y1   = prior_y_q;
    job_now.x2   = vx;
    job_now.y2   = vy;
    job_now.qx   = hq_x_q;
    job_now.qy   = hq_y_q;
    job_now.clr  = first_vertex_i;
    job_now.test = !first_vertex_i;
    // first and last together: the closing edge is flat, emit straight away
    job_now.emit = first_vertex_i && last_vertex_i;

    job_close      = '0;
    job_close.test = 1'b1;
    job_close.emit = 1'b1;
    job_close.x1   = vx;
    job_close.y1   = vy;
    job_close.x2   = start_x_q;
    job_close.y2   = start_y_q;
    job_close.qx   = hq_x_q;
    job_close.qy   = hq_y_q;
  end

  assign q_push_o = pend_q ? !q_full_i : accept;
  assign q_data_o = pend_q ? pend_job_q : job_now;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_job_q <= job_close;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= '0;
      start_y_q <= '0;
      prior_x_q <= '0;
      prior_y_q <= '0;
      hq_x_q    <= '0;
      hq_y_q    <= '0;
      pend_q    <= 1'b0;
    end else begin
      if (pend_q && !q_full_i) begin
        pend_q <= 1'b0;
      end
      if (accept) begin
        if (first_vertex_i) begin
          hq_x_q    <= COORD_BITS'(query_x_i);
          hq_y_q    <= COORD_BITS'(query_y_i);
          start_x_q <= vx;
          start_y_q <= vy;
        end
        prior_x_q <= vx;
        prior_y_q <= vy;
        pend_q    <= last_vertex_i && !first_vertex_i;
      end
    end
  end

endmodule

// ===== rtl/pip_back.sv =====
// Back end: exact edge-crossing test with one shared multiplier, count and result.
module pip_back
  import pip_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [TOL_BITS-1:0]       tol_i,
  input  logic                      q_empty_i,
  input  edge_job_t                 q_data_i,
  output logic                      q_pop_o,
  input  logic                      res_pop_i,
  output logic                      res_empty_o,
  output logic                      inside_o,
  output logic [OUT_COUNT_BITS-1:0] count_o
);

  localparam int IdxBits = $clog2(NUM_PRODS);

  back_state_e state_q, state_d;
  edge_job_t   job_q;

  logic signed [DIFF_BITS-1:0] x1, y1, x2, y2, qx, qy;
  logic signed [DIFF_BITS-1:0] dx, dy, dq, ax, fx, far_mq, tol_s;
  logic signed [DIFF_BITS-1:0] dx_q, dy_q, dq_q, ax_q, fx_q;
  logic                        swap, skip, xmode_q, yok_q, dxpos_q;

  logic [IdxBits-1:0]          idx_q;
  logic signed [DIFF_BITS-1:0] op_a, op_b;
  logic [COORD_BITS-1:0]       mag_a, mag_b;
  logic [PROD_BITS-1:0]        prod;
  logic [PROD_BITS-1:0]        mag_q [NUM_PRODS];
  logic                        neg_q [NUM_PRODS];
  logic signed [SPROD_BITS-1:0] sp_q [NUM_PRODS];
  logic signed [SPROD_BITS-1:0] lo_v, hi_v;
  logic                        span_ok, cross_d, cross_q;

  logic [COUNT_BITS-1:0]       cnt_q, cnt_new, cnt_base;
  logic                        par_q, par_new, par_base;
  logic                        res_valid_q, res_inside_q, commit_go;
  logic [COUNT_BITS-1:0]       res_count_q;

  function automatic logic [COORD_BITS-1:0] mag(input logic signed [DIFF_BITS-1:0] v);
    logic signed [DIFF_BITS-1:0] a;
    a   = (v < 0) ? -v : v;
    mag = COORD_BITS'(a);
  endfunction

  // order the edge bottom to top
  assign swap   = job_q.y1 > job_q.y2;
  assign x1     = DIFF_BITS'(swap ? job_q.x2 : job_q.x1);
  assign y1     = DIFF_BITS'(swap ? job_q.y2 : job_q.y1);
  assign x2     = DIFF_BITS'(swap ? job_q.x1 : job_q.x2);
  assign y2     = DIFF_BITS'(swap ? job_q.y1 : job_q.y2);
  assign qx     = DIFF_BITS'(job_q.qx);
  assign qy     = DIFF_BITS'(job_q.qy);
  assign dx     = x2 - x1;
  assign dy     = y2 - y1;
  assign dq     = qy - y1;
  assign ax     = qx - x1;
  assign fx     = FAR_COORD - x1;
  assign far_mq = FAR_COORD - qx;
  assign tol_s  = DIFF_BITS'(tol_i);
  assign skip   = (mag(dy) <= COORD_BITS'(tol_i)) || (far_mq <= tol_s);

  always_comb begin
    case (idx_q)
      IdxBits'(0): begin
        op_a = ax_q;
        op_b = dy_q;
      end
      IdxBits'(1): begin
        op_a = dx_q;
        op_b = dq_q;
      end
      IdxBits'(2): begin
        op_a = fx_q;
        op_b = dy_q;
      end
      default: begin
        op_a = dx_q;
        op_b = dy_q;
      end
    endcase
  end

  assign mag_a = mag(op_a);
  assign mag_b = mag(op_b);
  assign prod  = PROD_BITS'(mag_a) * PROD_BITS'(mag_b);

  // products: 0 = (qx-x1)*dy, 1 = dx*dq, 2 = (far-x1)*dy, 3 = dx*dy
  assign lo_v    = dxpos_q ? '0 : sp_q[3];
  assign hi_v    = dxpos_q ? sp_q[3] : '0;
  assign span_ok = xmode_q ? ((lo_v < sp_q[1]) && (sp_q[1] < hi_v)) : yok_q;
  assign cross_d = (sp_q[0] < sp_q[1]) && (sp_q[1] < sp_q[2]) && span_ok;

  // a first vertex starts the run from a cleared count and parity
  assign cnt_base  = job_q.clr ? '0 : cnt_q;
  assign par_base  = job_q.clr ? 1'b0 : par_q;
  assign par_new   = par_base ^ cross_q;
  assign cnt_new   = (cross_q && (cnt_base != '1)) ? cnt_base + 1'b1 : cnt_base;
  assign commit_go = !job_q.emit || !res_valid_q || res_pop_i;

  assign q_pop_o     = (state_q == ST_IDLE) && !q_empty_i;
  assign res_empty_o = !res_valid_q;
  assign inside_o    = res_inside_q;
  assign count_o     = OUT_COUNT_BITS'(res_count_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        state_d = (!job_q.test || skip) ? ST_COMMIT : ST_MUL;
      end
      ST_MUL: begin
        if (idx_q == IdxBits'(NUM_PRODS - 1)) state_d = ST_SIGN;
      end
      ST_SIGN: begin
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (commit_go) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      job_q <= q_data_i;
    end
    if (state_q == ST_LOAD) begin
      dx_q    <= dx;
      dy_q    <= dy;
      dq_q    <= dq;
      ax_q    <= ax;
      fx_q    <= fx;
      xmode_q <= mag(dx) > COORD_BITS'(tol_i);
      yok_q   <= (y1 < qy) && (qy < y2);
      dxpos_q <= dx > 0;
    end
    if (state_q == ST_MUL) begin
      mag_q[idx_q] <= prod;
      neg_q[idx_q] <= (op_a < 0) ^ (op_b < 0);
    end
    if (state_q == ST_SIGN) begin
      for (int i = 0; i < NUM_PRODS; i++) begin
        sp_q[i] <= neg_q[i] ? -$signed({1'b0, mag_q[i]}) : $signed({1'b0, mag_q[i]});
      end
    end
    if (state_q == ST_COMMIT && job_q.emit && commit_go) begin
      res_inside_q <= par_new;
      res_count_q  <= cnt_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      cross_q     <= 1'b0;
      cnt_q       <= '0;
      par_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_pop_i && res_valid_q) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_LOAD: begin
          idx_q   <= '0;
          cross_q <= 1'b0;
        end
        ST_MUL: begin
          idx_q <= idx_q + 1'b1;
        end
        ST_EVAL: begin
          cross_q <= cross_d;
        end
        ST_COMMIT: begin
          if (commit_go) begin
            if (job_q.clr || job_q.emit) begin
              cnt_q <= '0;
              par_q <= 1'b0;
            end else begin
              cnt_q <= cnt_new;
              par_q <= par_new;
            end
            if (job_q.emit) begin
              res_valid_q <= 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

`include "point_in_polygon_test_top_defines.svh"

  `PIP_ASSERT_NEXT(a_emit_fills, state_q == ST_COMMIT && job_q.emit && commit_go, res_valid_q, "result lost")
  `PIP_ASSERT_NEXT(a_untested_skip, state_q == ST_LOAD && !job_q.test, state_q == ST_COMMIT && !cross_q, "untested job crossed")
  `PIP_ASSERT_NEXT(a_pop_loads, q_pop_o, state_q == ST_LOAD, "popped job not loaded")

endmodule

// ===== rtl/point_in_polygon_test_top.sv =====
// Top level of the even-odd ray casting point-in-polygon tester.
// Throughput: one vertex per cycle while the job queue has room and no closing edge is
//   pending; each edge runs LOAD, MUL, SIGN, EVAL, COMMIT (only LOAD, COMMIT if untested
//   or dy or far-qx is in tolerance). A last non-first vertex adds the closing edge.
// The shared 32x32 magnitude multiplier, one product per cycle, sets the edge time.
// Reset: async, active low; clears queue, run state, count, result valid; tolerance 66.
module point_in_polygon_test_top
  import pip_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // vertex requests
  input  logic                       push,
  output logic                       full,
  input  logic signed [IN_BITS-1:0]  query_x_i,
  input  logic signed [IN_BITS-1:0]  query_y_i,
  input  logic signed [IN_BITS-1:0]  vertex_x_i,
  input  logic signed [IN_BITS-1:0]  vertex_y_i,
  input  logic                       first_vertex_i,
  input  logic                       last_vertex_i,
  // result requests
  output logic                       empty,
  input  logic                       pop,
  output logic                       inside_res_o,
  output logic [OUT_COUNT_BITS-1:0]  crossing_count_o,
  // tolerance write channel
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [TOL_BITS-1:0]        cfg_data_i
);

  logic [TOL_BITS-1:0] tol_q;
  logic                q_full, q_empty, q_push, q_pop;
  edge_job_t           q_wdata, q_rdata;

  // Tolerance register, always ready: user writes only while block is idle; not enforced.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_valid_i) begin
      tol_q <= cfg_data_i;
    end
  end

  // Front: hold run state, make an edge job per vertex plus the closing edge of a run.
  pip_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .query_x_i      (query_x_i),
    .query_y_i      (query_y_i),
    .vertex_x_i     (vertex_x_i),
    .vertex_y_i     (vertex_y_i),
    .first_vertex_i (first_vertex_i),
    .last_vertex_i  (last_vertex_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_data_o       (q_wdata)
  );

  // Queue decouples vertex intake from the multi-cycle edge test.
  pip_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_rdata)
  );

  // Back: test each edge exactly, advance count and parity, drive the result register.
  pip_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tol_i       (tol_q),
    .q_empty_i   (q_empty),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .res_pop_i   (pop),
    .res_empty_o (empty),
    .inside_o    (inside_res_o),
    .count_o     (crossing_count_o)
  );

endmodule
